/* rtl/core/iwo_pkg.sv */
// Shared types, widths and codes for the interpolating wavetable oscillator.
`timescale 1ns / 1ps

package iwo_pkg;

  localparam int TABLE_ENTRIES = 2048;
  localparam int FRACTION_BITS = 16;
  localparam int SAMPLE_BITS   = 16;

  localparam int ADDR_BITS  = $clog2(TABLE_ENTRIES);
  localparam int PHASE_BITS = ADDR_BITS + FRACTION_BITS;
  localparam int STEP_BITS  = 27;
  localparam int LEVEL_BITS = 16;
  localparam int CFG_BITS   = (STEP_BITS > LEVEL_BITS) ? STEP_BITS : LEVEL_BITS;
  localparam int CFG_INDEX_BITS = 1;

  // Fraction bits that take part in the interpolation.
  localparam int FUSE_BITS = (FRACTION_BITS > 16) ? 16 : FRACTION_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + FUSE_BITS + 2;
  localparam int SCALE_BITS = SAMPLE_BITS + LEVEL_BITS + 1;
  localparam int LEVEL_SHIFT = 15;

  localparam logic [STEP_BITS-1:0]  STEP_RESET  = '0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(8192);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PHASE_STEP = 1'b0,
    CFG_OUT_LEVEL  = 1'b1
  } cfg_index_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } item_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mem_write;
    logic mem_read;
    logic rd_next;
    logic cap_s0;
    logic do_mul;
    logic do_mix;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/iwo_if.sv */
// Stream interfaces for input items and output samples.
`timescale 1ns / 1ps

interface iwo_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic [iwo_pkg::ADDR_BITS-1:0]          table_address;
  logic signed [iwo_pkg::SAMPLE_BITS-1:0] table_value;

  modport source (output valid, output cmd, output table_address, output table_value,
                  input ready);
  modport sink   (input valid, input cmd, input table_address, input table_value,
                  output ready);
endinterface

interface iwo_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [iwo_pkg::SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/core/iwo_ctrl.sv */
// Controller state machine sequencing loads and ticks.
`timescale 1ns / 1ps

module iwo_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_cmd,
  output logic                item_ready,
  input  iwo_pkg::dp_status_t status,
  output iwo_pkg::dp_cmd_t    command
);

  iwo_pkg::state_t state;
  iwo_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iwo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iwo_pkg::ST_IDLE: begin
        if (item_valid && (item_cmd == iwo_pkg::CMD_TICK)) state_next = iwo_pkg::ST_RD0;
      end
      iwo_pkg::ST_RD0: state_next = iwo_pkg::ST_RD1;
      iwo_pkg::ST_RD1: state_next = iwo_pkg::ST_MUL;
      iwo_pkg::ST_MUL: state_next = iwo_pkg::ST_MIX;
      iwo_pkg::ST_MIX: state_next = iwo_pkg::ST_OUT;
      iwo_pkg::ST_OUT: begin
        if (status.out_free) state_next = iwo_pkg::ST_IDLE;
      end
      default: state_next = iwo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    command    = '0;
    unique case (state)
      iwo_pkg::ST_IDLE: begin
        item_ready        = 1'b1;
        command.mem_write = item_valid && (item_cmd == iwo_pkg::CMD_LOAD);
      end
      iwo_pkg::ST_RD0: begin
        command.mem_read = 1'b1;
      end
      iwo_pkg::ST_RD1: begin
        command.mem_read = 1'b1;
        command.rd_next  = 1'b1;
        command.cap_s0   = 1'b1;
      end
      iwo_pkg::ST_MUL: command.do_mul = 1'b1;
      iwo_pkg::ST_MIX: command.do_mix = 1'b1;
      iwo_pkg::ST_OUT: command.out_load = status.out_free;
      default: ;
    endcase
  end

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item_cmd == iwo_pkg::CMD_LOAD)) |=>
      (state == iwo_pkg::ST_IDLE))
    else $error("load beat left the idle state");

  a_tick_starts_read: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item_cmd == iwo_pkg::CMD_TICK)) |=>
      (state == iwo_pkg::ST_RD0))
    else $error("tick beat did not start the table read");

  a_load_needs_free: assert property (@(posedge clk) disable iff (rst)
    command.out_load |-> status.out_free)
    else $error("sample loaded into an occupied output register");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !(command.mem_read || command.do_mul || command.do_mix))
    else $error("item ready while a tick is in progress");

endmodule

/* rtl/core/iwo_datapath.sv */
// Datapath: table store, phase accumulator, interpolation, scaling and output register.
`timescale 1ns / 1ps

module iwo_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [iwo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [iwo_pkg::CFG_BITS-1:0]        cfg_data,
  iwo_item_if.sink                            items,
  iwo_sample_if.source                        samples,
  input  iwo_pkg::dp_cmd_t                    command,
  output iwo_pkg::dp_status_t                 status
);

  localparam int MSB = iwo_pkg::SCALE_BITS;

  logic signed [iwo_pkg::SAMPLE_BITS-1:0] mem [iwo_pkg::TABLE_ENTRIES];
  logic signed [iwo_pkg::SAMPLE_BITS-1:0] rdata;
  logic signed [iwo_pkg::SAMPLE_BITS-1:0] s0;
  logic signed [iwo_pkg::PROD_BITS-1:0]   prod;
  logic signed [iwo_pkg::SCALE_BITS-1:0]  scaled;
  logic signed [iwo_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   out_valid;

  logic [iwo_pkg::PHASE_BITS-1:0] phase_acc;
  logic [iwo_pkg::STEP_BITS-1:0]  phase_step;
  logic [iwo_pkg::LEVEL_BITS-1:0] out_level;

  logic [iwo_pkg::ADDR_BITS-1:0]          idx0;
  logic [iwo_pkg::ADDR_BITS-1:0]          rd_addr;
  logic [iwo_pkg::FUSE_BITS-1:0]          frac;
  logic signed [iwo_pkg::SAMPLE_BITS:0]   diff;
  logic signed [iwo_pkg::PROD_BITS-1:0]   interp;
  logic signed [iwo_pkg::SAMPLE_BITS-1:0] mix;
  logic signed [MSB:0]                    rounded;
  logic signed [MSB:0]                    shifted;
  logic                                   sat_hi;
  logic                                   sat_lo;
  logic signed [iwo_pkg::SAMPLE_BITS-1:0] sample_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= iwo_pkg::STEP_RESET;
      out_level  <= iwo_pkg::LEVEL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        iwo_pkg::CFG_PHASE_STEP: phase_step <= cfg_data[iwo_pkg::STEP_BITS-1:0];
        iwo_pkg::CFG_OUT_LEVEL:  out_level  <= cfg_data[iwo_pkg::LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign idx0    = phase_acc[iwo_pkg::PHASE_BITS-1:iwo_pkg::FRACTION_BITS];
  assign rd_addr = command.rd_next ? idx0 + 1'b1 : idx0;
  assign frac    = phase_acc[iwo_pkg::FRACTION_BITS-1 -: iwo_pkg::FUSE_BITS];

  // Single-port table store.
  always_ff @(posedge clk) begin
    if (command.mem_write) begin
      mem[items.table_address] <= items.table_value;
    end else if (command.mem_read) begin
      rdata <= mem[rd_addr];
    end
  end

  assign diff    = {rdata[iwo_pkg::SAMPLE_BITS-1], rdata} - {s0[iwo_pkg::SAMPLE_BITS-1], s0};
  assign interp  = prod >>> iwo_pkg::FUSE_BITS;
  // The interpolated value lies between both entries, so a wrapping add is exact.
  assign mix     = s0 + interp[iwo_pkg::SAMPLE_BITS-1:0];
  assign rounded = {scaled[MSB-1], scaled} + (MSB+1)'(1 << (iwo_pkg::LEVEL_SHIFT - 1));
  assign shifted = rounded >>> iwo_pkg::LEVEL_SHIFT;
  assign sat_hi  = !shifted[MSB] && (|shifted[MSB-1:iwo_pkg::SAMPLE_BITS-1]);
  assign sat_lo  = shifted[MSB] && !(&shifted[MSB-1:iwo_pkg::SAMPLE_BITS-1]);

  always_comb begin
    sample_next = shifted[iwo_pkg::SAMPLE_BITS-1:0];
    if (sat_hi) sample_next = {1'b0, {(iwo_pkg::SAMPLE_BITS-1){1'b1}}};
    if (sat_lo) sample_next = {1'b1, {(iwo_pkg::SAMPLE_BITS-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (command.cap_s0) s0 <= rdata;
    if (command.do_mul) prod <= diff * $signed({1'b0, frac});
    if (command.do_mix) scaled <= mix * $signed({1'b0, out_level});
    if (command.out_load) sample <= sample_next;
  end

  // Advance the phase once the sample is delivered to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (command.out_load) begin
      phase_acc <= phase_acc + iwo_pkg::PHASE_BITS'(phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (command.out_load) begin
      out_valid <= 1'b1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free    = !out_valid || samples.ready;
  assign samples.valid      = out_valid;
  assign samples.sample_out = sample;

  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !command.out_load |=> $stable(phase_acc))
    else $error("phase moved without a delivered sample");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !samples.ready) |=> (out_valid && $stable(sample)))
    else $error("pending sample lost before its beat");

  a_valid_after_load: assert property (@(posedge clk) disable iff (rst)
    command.out_load |=> out_valid)
    else $error("loaded sample not offered on the output");

endmodule

/* rtl/core/interpolating_wavetable_oscillator_core.sv */
// Top level of the interpolating wavetable oscillator.
`timescale 1ns / 1ps

// Wavetable oscillator with linear interpolation. Software loads one period of
// a waveform, 2048 signed Q1.15 words, with load beats (cmd = 0); the store is
// undefined until written and has no clearing pass, so every entry a tick may
// touch must be loaded first. Each tick beat (cmd = 1) reads the two entries
// around the 27-bit phase (11 integer, 16 fraction bits), interpolates by the
// fraction, scales by out_level with round-half-up and saturation, and emits
// one sample beat; the phase then advances by phase_step modulo one period.
// A load is written while idle and the block stays ready. A tick holds the
// block from its beat through two reads of the single-port table store, the
// interpolation multiply, the gain multiply and the output load. A finished
// sample waits in the output register while the next item is accepted; a
// tick stalls only at its last step while the previous sample is not taken.
// Write configuration only while no tick is in progress.
module interpolating_wavetable_oscillator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [iwo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [iwo_pkg::CFG_BITS-1:0]       cfg_data,
  iwo_item_if.sink                           items,
  iwo_sample_if.source                       samples
);

  iwo_pkg::dp_cmd_t    command;
  iwo_pkg::dp_status_t status;

  // Sequence the load and tick steps.
  iwo_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_cmd   (items.cmd),
    .item_ready (items.ready),
    .status     (status),
    .command    (command)
  );

  // Hold the table, phase, arithmetic and output register.
  iwo_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .samples   (samples),
    .command   (command),
    .status    (status)
  );

endmodule
